FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the search block.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/fmsc_pkg.sv
package fmsc_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 17;
  localparam int CRIT_W = 3;
  localparam int DIGIT_W = 4;
  localparam int REM5_W = 4;
  localparam int NSUM_W = 7;

  localparam int MAX_ELEMENTS = 65536;
  localparam int POS_MAX = (1 << POS_W) - 1;
  localparam logic [POS_W-1:0] COUNT_CAP =
    POS_W'((MAX_ELEMENTS > POS_MAX) ? POS_MAX : MAX_ELEMENTS);

  localparam logic [CRIT_W-1:0] CRIT_EQUAL   = 3'd0;
  localparam logic [CRIT_W-1:0] CRIT_PARITY  = 3'd1;
  localparam logic [CRIT_W-1:0] CRIT_DIVIDES = 3'd2;
  localparam logic [CRIT_W-1:0] CRIT_DIGITS  = 3'd3;
  localparam logic [CRIT_W-1:0] CRIT_MOD5    = 3'd4;

  localparam logic CFG_CRITERION = 1'b0;
  localparam logic CFG_KEY       = 1'b1;

  localparam logic [DATA_W-1:0] POW10 [9] = '{
    32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
    32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
  };

  typedef logic [DATA_W-1:0] word_t;

  function automatic word_t magnitude(input word_t v);
    return v[DATA_W-1] ? word_t'(~v + 32'd1) : v;
  endfunction

  function automatic logic [DIGIT_W-1:0] digit_count(input word_t v);
    word_t m;
    logic [DIGIT_W-1:0] n;
    m = magnitude(v);
    n = 4'd1;
    for (int i = 0; i < 9; i++) begin
      if (m >= POW10[i]) n = n + 4'd1;
    end
    return n;
  endfunction

  // Since 16 is 1 mod 5, the sum of the nibbles keeps the remainder mod 5.
  function automatic logic [NSUM_W-1:0] nibble_sum(input word_t m);
    logic [4:0] p [4];
    logic [5:0] q [2];
    for (int i = 0; i < 4; i++) begin
      p[i] = {1'b0, m[8*i +: 4]} + {1'b0, m[8*i+4 +: 4]};
    end
    q[0] = {1'b0, p[0]} + {1'b0, p[1]};
    q[1] = {1'b0, p[2]} + {1'b0, p[3]};
    return {1'b0, q[0]} + {1'b0, q[1]};
  endfunction

  function automatic logic [2:0] mod5_reduce(input logic [NSUM_W-1:0] s);
    logic [NSUM_W-1:0] t;
    t = s;
    if (t >= 7'd80) t = t - 7'd80;
    if (t >= 7'd40) t = t - 7'd40;
    if (t >= 7'd20) t = t - 7'd20;
    if (t >= 7'd10) t = t - 7'd10;
    if (t >= 7'd5)  t = t - 7'd5;
    return t[2:0];
  endfunction

  // Remainder codes 0..4 for a non-negative dividend, 5..8 for -1..-4.
  function automatic logic [REM5_W-1:0] rem5_code(input logic neg, input logic [2:0] r);
    logic [REM5_W-1:0] c;
    c = {1'b0, r};
    if (neg && (c != 4'd0)) c = c + 4'd4;
    return c;
  endfunction

endpackage

FILE: rtl/core/fmsc_rem.sv
module fmsc_rem (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  fmsc_pkg::word_t      dividend,
  input  fmsc_pkg::word_t      divisor,
  output logic                 done,
  output fmsc_pkg::word_t      remainder
);
  import fmsc_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [4:0]        cnt_r;
  word_t             dvd_r;
  word_t             dvs_r;
  word_t             rem_r;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  word_t             rem_nxt;

  always_comb begin
    trial = {rem_r, dvd_r[DATA_W-1]};
    diff  = trial - {1'b0, dvs_r};
    rem_nxt = diff[DATA_W] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[DATA_W-2:0], 1'b0};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

  `include "assert_macros.svh"

  `ASSERT_CLK(a_no_restart, !(start && busy_r), "remainder unit restarted while busy")
  `ASSERT_CLK(a_rem_below_divisor, !done_r || (dvs_r == '0) || (rem_r < dvs_r), "remainder not below divisor")
  `ASSERT_NEXT(a_done_after_last_step, busy_r && !start && (cnt_r == 5'd31), done_r && !busy_r, "done missing after last step")

endmodule

FILE: rtl/core/first_match_search_by_criterion_top.sv
// Scans a stream of signed 32-bit elements for the first one that matches the key under
// the selected criterion (equal, same parity, element divides key, same decimal digit count,
// same truncated remainder mod 5); the beat with tlast closes the range and produces one
// result beat, other beats produce none. A beat is taken only when the block is idle: equal,
// parity, digit count, the unused codes and a zero element under divides pass through S_EVAL
// and S_UPDATE, mod 5 adds S_MOD5, and divides waits in S_DIV for the bit-serial remainder
// unit, which needs 32 steps after its load; once a match is seen, later elements of the
// range skip S_DIV and S_MOD5. The last element of a range passes through S_EMIT to load the
// result, and waits there while the previous result beat has not been taken.
module first_match_search_by_criterion_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] element_value
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [16:0] position, [48:17] matched_value, [55:49] zero
  output logic        out_tuser   // [0] found
);
  import fmsc_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_EVAL, S_DIV, S_MOD5, S_UPDATE, S_EMIT} state_t;

  state_t              st_r;
  logic [CRIT_W-1:0]   crit_r;
  word_t               key_r;
  word_t               elem_r;
  logic                last_r;
  logic                hit_r;
  logic [NSUM_W-1:0]   sum_e_r;
  logic [NSUM_W-1:0]   sum_k_r;
  logic                match_seen_r;
  logic [POS_W-1:0]    count_r;
  logic [POS_W-1:0]    idx_r;
  word_t               mval_r;
  logic                out_valid_r;
  logic                out_found_r;
  logic [POS_W-1:0]    out_pos_r;
  word_t               out_val_r;

  word_t               elem_mag;
  word_t               key_mag;
  logic                rem_start;
  logic                rem_done;
  word_t               rem_val;
  logic                simple_hit;

  assign elem_mag = magnitude(elem_r);
  assign key_mag  = magnitude(key_r);

  always_comb begin
    case (crit_r)
      CRIT_EQUAL:  simple_hit = (elem_r == key_r);
      CRIT_PARITY: simple_hit = (elem_r[0] == key_r[0]);
      CRIT_DIGITS: simple_hit = (digit_count(elem_r) == digit_count(key_r));
      default:     simple_hit = 1'b0;
    endcase
  end

  assign rem_start = (st_r == S_EVAL) && !match_seen_r && (crit_r == CRIT_DIVIDES) &&
                     (elem_r != '0);

  fmsc_rem u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (rem_start),
    .dividend  (key_mag),
    .divisor   (elem_mag),
    .done      (rem_done),
    .remainder (rem_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      crit_r       <= CRIT_EQUAL;
      key_r        <= '0;
      match_seen_r <= 1'b0;
      count_r      <= '0;
      idx_r        <= '0;
      mval_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_CRITERION) crit_r <= cfg_wdata[CRIT_W-1:0];
        else                          key_r  <= cfg_wdata;
      end
      if (out_valid_r && out_tready && (st_r != S_EMIT)) out_valid_r <= 1'b0;

      unique case (st_r)
        S_IDLE: begin
          if (in_tvalid) begin
            elem_r <= in_tdata;
            last_r <= in_tlast;
            st_r   <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (rem_start) begin
            st_r <= S_DIV;
          end else if (!match_seen_r && (crit_r == CRIT_MOD5)) begin
            sum_e_r <= nibble_sum(elem_mag);
            sum_k_r <= nibble_sum(key_mag);
            st_r    <= S_MOD5;
          end else begin
            hit_r <= !match_seen_r && simple_hit;
            st_r  <= S_UPDATE;
          end
        end
        S_DIV: begin
          if (rem_done) begin
            hit_r <= (rem_val == '0);
            st_r  <= S_UPDATE;
          end
        end
        S_MOD5: begin
          hit_r <= (rem5_code(elem_r[DATA_W-1], mod5_reduce(sum_e_r)) ==
                    rem5_code(key_r[DATA_W-1], mod5_reduce(sum_k_r)));
          st_r  <= S_UPDATE;
        end
        S_UPDATE: begin
          if (hit_r) begin
            match_seen_r <= 1'b1;
            idx_r        <= count_r;
            mval_r       <= elem_r;
          end
          if (count_r < COUNT_CAP) count_r <= count_r + 17'd1;
          st_r <= last_r ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_found_r  <= match_seen_r;
            out_pos_r    <= match_seen_r ? idx_r : count_r;
            out_val_r    <= match_seen_r ? mval_r : '0;
            match_seen_r <= 1'b0;
            count_r      <= '0;
            idx_r        <= '0;
            mval_r       <= '0;
            st_r         <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {7'd0, out_val_r, out_pos_r};

  `include "assert_macros.svh"

  `ASSERT_NEXT(a_accept_to_eval, in_tvalid && in_tready, st_r == S_EVAL, "beat not evaluated")
  `ASSERT_CLK(a_done_in_div, !rem_done || (st_r == S_DIV), "remainder done outside divide")
  `ASSERT_CLK(a_no_match_zero, !out_valid_r || out_found_r || (out_val_r == '0), "value, no match")

endmodule
